[sv/matbl_pkg.sv]
package matbl_pkg;

  // Field widths of a request and a result.
  localparam int KEY_W  = 48;
  localparam int PORT_W = 16;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  // Default number of slots in the table.
  localparam int TABLE_SIZE_DEF = 32;

  // The key is folded into its home slot one byte per cycle, top byte first.
  localparam int FOLD_BITS  = 8;
  localparam int FOLD_STEPS = KEY_W / FOLD_BITS;
  localparam int STEP_W     = $clog2(FOLD_STEPS);

  // Request codes.
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Slot states.
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_GONE  = 2'd2
  } slot_state_t;

  // One table entry as it is held in the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PORT_W-1:0] port;
    slot_state_t       st;
  } slot_t;

endpackage

[sv/mac_address_table_hash.sv]
// MAC address table: an open-addressing hash table that maps 48-bit MAC keys to 16-bit
// port numbers, held in one slot memory with a registered read. The home slot is the key
// modulo TABLE_SIZE and probing is linear with wrap-around. A request (insert, search or
// delete in in_tuser) is accepted in the idle state, its key is folded into its home slot
// a byte at a time, the slots are then probed with reads issued back to back, and the
// result is handed to the output register once that register is free or being taken.
// After reset the block sweeps the memory to mark every slot empty, one slot per cycle,
// and accepts no request during the sweep. The next request is accepted while an earlier
// result still waits to be taken.
module mac_address_table_hash
  import matbl_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [KEY_W+PORT_W-1:0]       in_tdata,   // mac_key [47:0], port_value [63:48]
  input  logic [FUNC_W-1:0]             in_tuser,   // func [1:0]
  // Result channel.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [PORT_W-1:0]             out_tdata,  // port_out [15:0]
  output logic [STAT_W-1:0]             out_tuser   // status [1:0]
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W:0]   TBL_N    = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    clr_r;
  logic [STEP_W-1:0]   step_r;
  logic [FUNC_W-1:0]   func_r;
  logic [KEY_W-1:0]    key_r;
  logic [KEY_W-1:0]    shf_r;
  logic [PORT_W-1:0]   port_r;
  logic [IDX_W-1:0]    rem_r;
  logic [IDX_W-1:0]    cur_r;
  logic [IDX_W-1:0]    cnt_r;
  logic [STAT_W-1:0]   res_st_r;
  logic [PORT_W-1:0]   res_port_r;
  logic                out_tvalid_r;
  logic [STAT_W-1:0]   out_st_r;
  logic [PORT_W-1:0]   out_port_r;

  // Slot memory and its registered read word.
  slot_t               mem [TABLE_SIZE];
  slot_t               mem_q;

  logic [IDX_W-1:0]    rem_nxt;
  logic                hash_last;
  logic [IDX_W-1:0]    cur_nxt;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  slot_t               wr_data;
  logic                probe_end;
  logic                probe_wr;
  logic [STAT_W-1:0]   probe_st;
  logic [PORT_W-1:0]   probe_port;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_port_r;
  assign out_tuser  = out_st_r;

  // Fold the next byte of the key into the running remainder, one bit per step.
  always_comb begin
    logic [IDX_W:0] t;
    rem_nxt = rem_r;
    for (int b = 0; b < FOLD_BITS; b++) begin
      t = {rem_nxt, shf_r[KEY_W-1-b]};
      if (t >= TBL_N) begin
        t = t - TBL_N;
      end
      rem_nxt = t[IDX_W-1:0];
    end
  end

  assign hash_last = (step_r == STEP_W'(FOLD_STEPS - 1));
  assign cur_nxt   = (cur_r == LAST_IDX) ? '0 : cur_r + 1'b1;

  // The next slot is read while the current one is being examined; nothing is
  // written until the probe ends, so these early reads are always safe.
  assign rd_en   = (state_r == S_PROBE) || (state_r == S_HASH && hash_last);
  assign rd_addr = (state_r == S_PROBE) ? cur_nxt : rem_nxt;

  // Examine the slot word that has just been read.
  always_comb begin
    logic is_empty;
    logic is_hit;
    logic is_last;
    is_empty   = (mem_q.st == SLOT_EMPTY);
    is_hit     = (mem_q.st == SLOT_USED) && (mem_q.key == key_r);
    is_last    = (cnt_r == LAST_IDX);
    probe_end  = 1'b0;
    probe_wr   = 1'b0;
    probe_st   = ST_MISS;
    probe_port = '0;
    case (func_r)
      FN_INSERT: begin
        if (mem_q.st != SLOT_USED) begin
          probe_end = 1'b1;
          probe_wr  = 1'b1;
          probe_st  = ST_OK;
        end else if (is_last) begin
          probe_end = 1'b1;
          probe_st  = ST_FULL;
        end
      end
      FN_SEARCH, FN_DELETE: begin
        if (is_empty) begin
          probe_end = 1'b1;
        end else if (is_hit) begin
          probe_end  = 1'b1;
          probe_wr   = (func_r == FN_DELETE);
          probe_st   = ST_OK;
          probe_port = mem_q.port;
        end else if (is_last) begin
          probe_end = 1'b1;
        end
      end
      default: begin
        probe_end = 1'b1;
      end
    endcase
  end

  // Write port: the clearing sweep after reset, or the slot update that ends a probe.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = mem_q;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '{key: '0, port: '0, st: SLOT_EMPTY};
    end else if (state_r == S_PROBE && probe_wr) begin
      wr_en = 1'b1;
      if (func_r == FN_INSERT) begin
        wr_data = '{key: key_r, port: port_r, st: SLOT_USED};
      end else begin
        wr_data = '{key: mem_q.key, port: mem_q.port, st: SLOT_GONE};
      end
    end
  end

  // Slot memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Request sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // A result that is taken leaves the output register empty, unless a new one
      // is loaded in the same cycle below.
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            func_r  <= in_tuser;
            key_r   <= in_tdata[KEY_W-1:0];
            shf_r   <= in_tdata[KEY_W-1:0];
            port_r  <= in_tdata[KEY_W+PORT_W-1:KEY_W];
            rem_r   <= '0;
            step_r  <= '0;
            if (in_tuser inside {FN_INSERT, FN_SEARCH, FN_DELETE}) begin
              state_r <= S_HASH;
            end else begin
              res_st_r   <= ST_MISS;
              res_port_r <= '0;
              state_r    <= S_DONE;
            end
          end
        end
        S_HASH: begin
          rem_r  <= rem_nxt;
          shf_r  <= shf_r << FOLD_BITS;
          step_r <= step_r + 1'b1;
          if (hash_last) begin
            cur_r   <= rem_nxt;
            cnt_r   <= '0;
            state_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (probe_end) begin
            res_st_r   <= probe_st;
            res_port_r <= probe_port;
            state_r    <= S_DONE;
          end else begin
            cur_r <= cur_nxt;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_st_r     <= res_st_r;
            out_port_r   <= res_port_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
